// ----- rtl/pmq_pkg.sv -----
// Shared types, widths and helpers for the priority message queue.
// Used by pmq_scan_track and priority_message_queue_core; no dependencies.
`default_nettype none

package pmq_pkg;

    // Fixed field widths of the channel beats.
    localparam int PRIO_W    = 4;
    localparam int PAYLOAD_W = 64;
    localparam int TOP_W     = 5;
    localparam int FILL_W    = 5;

    // One bit per priority value that a 4-bit request can carry.
    localparam int MASK_W = 1 << PRIO_W;

    // Default configuration of the queue.
    localparam int DEF_QUEUE_DEPTH     = 16;
    localparam int DEF_PRIORITY_LEVELS = 16;
    localparam int DEF_PAYLOAD_BITS    = 64;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [MASK_W-1:0] prio_mask_t;

    typedef struct packed {
        logic                 op;
        logic [PRIO_W-1:0]    priority_req;
        logic [PAYLOAD_W-1:0] payload;
    } in_beat_t;

    typedef struct packed {
        logic                 ok;
        logic [PRIO_W-1:0]    out_priority;
        logic [PAYLOAD_W-1:0] out_payload;
        logic [TOP_W-1:0]     top_priority;
        logic [FILL_W-1:0]    fill_count;
    } out_beat_t;

    // Control from the sequencer to the scan tracker.
    typedef struct packed {
        logic clear;
        logic beat;
    } scan_ctl_t;

    // Index of the lowest set bit of a priority mask (zero for an empty mask).
    function automatic logic [TOP_W-1:0] lowest_set(input prio_mask_t mask);
        logic [TOP_W-1:0] pos;
        pos = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                pos = TOP_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pmq_scan_track.sv -----
// Running minimum tracker fed by the entries read during a pop scan.
// Depends on pmq_pkg for the mask type and the control struct.
`default_nettype none

module pmq_scan_track
    import pmq_pkg::*;
#(
    parameter int IDX_W        = 4,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire scan_ctl_t               ctl,
    input  wire logic [IDX_W-1:0]        beat_idx,
    input  wire logic [PRIO_W-1:0]       beat_prio,
    input  wire logic [PAYLOAD_BITS-1:0] beat_payload,
    output      logic [IDX_W-1:0]        win_idx,
    output      logic [PRIO_W-1:0]       win_prio,
    output      logic [PAYLOAD_BITS-1:0] win_payload,
    output      prio_mask_t              rest_mask
);

    logic                    have_reg, have_next;
    logic                    dup_reg, dup_next;
    prio_mask_t              all_mask_reg, all_mask_next;
    logic [IDX_W-1:0]        win_idx_reg;
    logic [PRIO_W-1:0]       win_prio_reg;
    logic [PAYLOAD_BITS-1:0] win_pay_reg;
    logic                    take_new;

    // A strictly smaller priority replaces the best; an equal one marks a duplicate,
    // so the oldest entry of the minimum priority wins.
    assign take_new = ctl.beat && (!have_reg || (beat_prio < win_prio_reg));

    always_comb begin
        have_next     = have_reg;
        dup_next      = dup_reg;
        all_mask_next = all_mask_reg;
        if (ctl.clear) begin
            have_next     = 1'b0;
            dup_next      = 1'b0;
            all_mask_next = '0;
        end else if (ctl.beat) begin
            all_mask_next = all_mask_reg | (prio_mask_t'(1) << beat_prio);
            have_next     = 1'b1;
            if (take_new) begin
                dup_next = 1'b0;
            end else if (beat_prio == win_prio_reg) begin
                dup_next = 1'b1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg     <= 1'b0;
            dup_reg      <= 1'b0;
            all_mask_reg <= '0;
        end else begin
            have_reg     <= have_next;
            dup_reg      <= dup_next;
            all_mask_reg <= all_mask_next;
        end
    end

    // Best entry so far.
    always_ff @(posedge aclk) begin
        if (take_new && !ctl.clear) begin
            win_idx_reg  <= beat_idx;
            win_prio_reg <= beat_prio;
            win_pay_reg  <= beat_payload;
        end
    end

    assign win_idx     = win_idx_reg;
    assign win_prio    = win_prio_reg;
    assign win_payload = win_pay_reg;

    // Priorities left once the best entry is removed.
    assign rest_mask = dup_reg ? all_mask_reg
                               : (all_mask_reg & ~(prio_mask_t'(1) << win_prio_reg));

endmodule

`default_nettype wire

// ----- rtl/priority_message_queue_core.sv -----
// Priority message queue: entries live in one synchronous RAM of QUEUE_DEPTH words.
// A push, an empty pop or a refused push goes straight to the output stage; a pop reads
// every entry once (one read per entry), then takes the winner out at the head, or moves
// the later entries down a slot to close the gap before the result is handed off.
// One item at a time: the next beat is taken once the result enters the output register.
// Reset (aresetn, synchronous, low) empties the queue; RAM contents are not cleared.
`default_nettype none

module priority_message_queue_core
    import pmq_pkg::*;
#(
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
    parameter int PAYLOAD_BITS    = DEF_PAYLOAD_BITS
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output      logic      s_ready,
    input  wire in_beat_t  s_data,
    output      logic      m_valid,
    input  wire logic      m_ready,
    output      out_beat_t m_data
);

    localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = PRIO_W + PAYLOAD_BITS;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(QUEUE_DEPTH);
    localparam logic [PRIO_W-1:0] PRIO_MAX   = PRIO_W'(PRIORITY_LEVELS - 1);
    localparam logic [TOP_W-1:0]  TOP_EMPTY  = TOP_W'(PRIORITY_LEVELS);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : IDX_W'(i - 1'b1);
    endfunction

    // Control state.
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    prio_mask_t       mask_reg, mask_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             m_valid_reg, m_valid_next;

    // Data registers.
    logic [IDX_W-1:0]        tag_reg, tag_next;
    logic                    res_ok_reg, res_ok_next;
    logic [PRIO_W-1:0]       res_prio_reg, res_prio_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;
    out_beat_t               m_data_reg, m_data_next;

    // Queue RAM.
    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] mem_rdata_reg;
    logic               mem_we, mem_re;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // Scan tracker connection.
    scan_ctl_t               scan_ctl;
    logic [IDX_W-1:0]        win_idx;
    logic [PRIO_W-1:0]       win_prio;
    logic [PAYLOAD_BITS-1:0] win_payload;
    prio_mask_t              rest_mask;

    logic [PRIO_W-1:0] push_prio;
    logic [IDX_W-1:0]  shift_nx;
    logic              out_free;

    // Requests past the last level saturate to the least urgent level.
    assign push_prio = (32'(s_data.priority_req) >= PRIORITY_LEVELS) ? PRIO_MAX
                                                                      : s_data.priority_req;
    assign shift_nx  = idx_inc(ptr_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);

    pmq_scan_track #(
        .IDX_W        (IDX_W),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (scan_ctl),
        .beat_idx     (tag_reg),
        .beat_prio    (mem_rdata_reg[PAYLOAD_BITS +: PRIO_W]),
        .beat_payload (mem_rdata_reg[PAYLOAD_BITS-1:0]),
        .win_idx      (win_idx),
        .win_prio     (win_prio),
        .win_payload  (win_payload),
        .rest_mask    (rest_mask)
    );

    // Sequencer: push, scan for the winner, close the gap, hand off the result.
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        mask_next     = mask_reg;
        ptr_next      = ptr_reg;
        left_next     = left_reg;
        rd_vld_next   = 1'b0;
        m_valid_next  = m_valid_reg;
        tag_next      = tag_reg;
        res_ok_next   = res_ok_reg;
        res_prio_next = res_prio_reg;
        res_pay_next  = res_pay_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = tail_reg;
        mem_wdata     = {push_prio, s_data.payload[PAYLOAD_BITS-1:0]};
        mem_re        = 1'b0;
        mem_raddr     = ptr_reg;
        scan_ctl      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_ok_next   = 1'b0;
                    res_prio_next = '0;
                    res_pay_next  = '0;
                    state_next    = ST_FIN;
                    if (s_data.op == OP_PUSH) begin
                        if (count_reg != FULL_CNT) begin
                            mem_we      = 1'b1;
                            tail_next   = idx_inc(tail_reg);
                            count_next  = CNT_W'(count_reg + 1'b1);
                            mask_next   = mask_reg | (prio_mask_t'(1) << push_prio);
                            res_ok_next = 1'b1;
                        end
                    end else if (count_reg != '0) begin
                        ptr_next       = head_reg;
                        left_next      = count_reg;
                        scan_ctl.clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // One read per pending entry, oldest first.
                if (left_reg != '0) begin
                    mem_re      = 1'b1;
                    mem_raddr   = ptr_reg;
                    ptr_next    = idx_inc(ptr_reg);
                    left_next   = CNT_W'(left_reg - 1'b1);
                    rd_vld_next = 1'b1;
                    tag_next    = ptr_reg;
                end
                if (rd_vld_reg) begin
                    scan_ctl.beat = 1'b1;
                end
                // All entries seen: take the winner out.
                if (left_reg == '0 && !rd_vld_reg) begin
                    res_ok_next   = 1'b1;
                    res_prio_next = win_prio;
                    res_pay_next  = win_payload;
                    count_next    = CNT_W'(count_reg - 1'b1);
                    mask_next     = rest_mask;
                    if (win_idx == head_reg) begin
                        head_next  = idx_inc(head_reg);
                        state_next = ST_FIN;
                    end else begin
                        ptr_next   = win_idx;
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT: begin
                // Read the next entry while writing the previous one a slot lower;
                // the two addresses never coincide.
                if (shift_nx != tail_reg) begin
                    mem_re      = 1'b1;
                    mem_raddr   = shift_nx;
                    ptr_next    = shift_nx;
                    rd_vld_next = 1'b1;
                    tag_next    = ptr_reg;
                end
                if (rd_vld_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = tag_reg;
                    mem_wdata = mem_rdata_reg;
                end
                if (shift_nx == tail_reg && !rd_vld_reg) begin
                    tail_next  = idx_dec(tail_reg);
                    state_next = ST_FIN;
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.ok           = res_ok_reg;
                    m_data_next.out_priority = res_prio_reg;
                    m_data_next.out_payload  = PAYLOAD_W'(res_pay_reg);
                    m_data_next.top_priority = (mask_reg == '0) ? TOP_EMPTY
                                                                : lowest_set(mask_reg);
                    m_data_next.fill_count   = FILL_W'(count_reg);
                    state_next               = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            mask_reg    <= '0;
            ptr_reg     <= '0;
            left_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            mask_reg    <= mask_next;
            ptr_reg     <= ptr_next;
            left_reg    <= left_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Data registers.
    always_ff @(posedge aclk) begin
        tag_reg      <= tag_next;
        res_ok_reg   <= res_ok_next;
        res_prio_reg <= res_prio_next;
        res_pay_reg  <= res_pay_next;
        m_data_reg   <= m_data_next;
    end

    // Queue RAM: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
